@@ rtl/core/iohist_pkg.sv @@
// Package for the integral orientation histogram: widths, constants and item types.
package iohist_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_BINS_DEF  = 16;
    localparam int MAX_WIDTH_DEF = 1024;

    // Field widths
    localparam int MAG_W  = 16;
    localparam int ANG_W  = 16;
    localparam int COL_W  = 10;
    localparam int OBIN_W = 4;
    localparam int INT_W  = 40;
    localparam int ROW_W  = 26;
    localparam int FRAC_W = 16;

    // Internal bin and bin-count widths, sized for the largest bin parameter (64)
    localparam int BIN_W = 6;
    localparam int NB_W  = 7;

    // Orientation ranges in Q9.7 degrees
    localparam int RANGE_FULL = 360 * 128;
    localparam int RANGE_HALF = 180 * 128;

    // Both ranges are 45 times a power of two: pos = (ang * nb << shift) / 45
    localparam int DIV_K      = RANGE_HALF / 512;
    localparam int SHIFT_HALF = 7;
    localparam int SHIFT_FULL = 6;
    localparam int DIV_W      = 32;
    localparam int DIV_DIGIT  = 4;
    localparam int DIV_STEPS  = DIV_W / DIV_DIGIT;
    localparam int REM_W      = 6;

    // Configuration
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_ORIENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS    = 1'd1;
    localparam logic [CFG_DATA_W-1:0] NB_RESET = 5'd8;
    localparam logic [CFG_DATA_W-1:0] NB_MIN   = 5'd2;

    // Result queue depth in the back end
    localparam int OQ_DEPTH = 3;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [ANG_W-1:0] angle;
        logic [COL_W-1:0] column;
        logic             first_row;
    } t_in_item;

    typedef struct packed {
        logic [OBIN_W-1:0] bin_index;
        logic [INT_W-1:0]  integral_value;
        logic              last_bin;
    } t_out_item;

    typedef struct packed {
        logic            full;
        logic [NB_W-1:0] nb;
    } t_cfg;

    // One classified pixel handed from front to back
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] share1;
        logic [BIN_W-1:0] bin0;
        logic [BIN_W-1:0] bin1;
        logic [NB_W-1:0]  nb;
        logic [COL_W-1:0] col;
        logic             top;
        logic             clear;
    } t_job;

endpackage

@@ rtl/core/iohist_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module iohist_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/iohist_queue.sv @@
// Two-entry job queue between the front end and the back end.
module iohist_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  iohist_pkg::t_job  i_job,
    output logic              o_full,
    input  logic              i_pop,
    output iohist_pkg::t_job  o_job,
    output logic              o_empty
);

    iohist_pkg::t_job r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

endmodule

@@ rtl/core/iohist_front.sv @@
// Front end: takes a pixel, finds its bin position and splits the magnitude.
module iohist_front #(
    parameter int MAX_WIDTH = iohist_pkg::MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iohist_pkg::t_cfg     i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  iohist_pkg::t_in_item i_item,
    output logic                 o_push,
    output iohist_pkg::t_job     o_job,
    input  logic                 i_full
);

    localparam int MAG_W  = iohist_pkg::MAG_W;
    localparam int ANG_W  = iohist_pkg::ANG_W;
    localparam int COL_W  = iohist_pkg::COL_W;
    localparam int NB_W   = iohist_pkg::NB_W;
    localparam int BIN_W  = iohist_pkg::BIN_W;
    localparam int FRAC_W = iohist_pkg::FRAC_W;
    localparam int DIV_W  = iohist_pkg::DIV_W;
    localparam int DIG    = iohist_pkg::DIV_DIGIT;
    localparam int REM_W  = iohist_pkg::REM_W;
    localparam int STEP_W = $clog2(iohist_pkg::DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_MUL,
        S_DIV,
        S_MAG,
        S_PUSH
    } t_state;

    t_state              r_state;
    logic [MAG_W-1:0]    r_mag;
    logic [ANG_W-1:0]    r_ang;
    logic [COL_W-1:0]    r_col;
    logic                r_top;
    logic                r_clear;
    logic [NB_W-1:0]     r_nb;
    logic [DIV_W-1:0]    r_x;
    logic [DIV_W-1:0]    r_q;
    logic [REM_W-1:0]    r_rem;
    logic [STEP_W-1:0]   r_step;
    logic [BIN_W-1:0]    r_bin0;
    logic [BIN_W-1:0]    r_bin1;
    logic [MAG_W-1:0]    r_share1;

    logic [ANG_W-1:0]       range_q;
    logic [ANG_W-1:0]       ang_a;
    logic [ANG_W-1:0]       ang_b;
    logic [ANG_W+NB_W-1:0]  prod;
    logic [DIV_W-1:0]       x_val;
    logic [REM_W:0]         d_t;
    logic [REM_W-1:0]       d_rem;
    logic [DIG-1:0]         d_bits;
    logic [BIN_W-1:0]       bin0_raw;
    logic [BIN_W-1:0]       bin0;
    logic [NB_W-1:0]        bin0_inc;
    logic [BIN_W-1:0]       bin1;
    logic [2*MAG_W-1:0]     share_prod;
    logic                   col_ge;
    logic                   push;

    // Angle reduction: inputs stay below three half ranges, so two subtracts do
    always_comb begin
        range_q = i_cfg.full ? ANG_W'(iohist_pkg::RANGE_FULL)
                             : ANG_W'(iohist_pkg::RANGE_HALF);
        ang_a   = (r_ang >= range_q) ? r_ang - range_q : r_ang;
        ang_b   = (ang_a >= range_q) ? ang_a - range_q : ang_a;
    end

    always_comb begin
        prod  = {{NB_W{1'b0}}, r_ang} * {{ANG_W{1'b0}}, r_nb};
        x_val = i_cfg.full ? (DIV_W'(prod) << iohist_pkg::SHIFT_FULL)
                           : (DIV_W'(prod) << iohist_pkg::SHIFT_HALF);
    end

    // Long division by 45, one digit of four quotient bits a cycle
    always_comb begin
        d_rem  = r_rem;
        d_bits = '0;
        d_t    = '0;
        for (int k = 0; k < DIG; k++) begin
            d_t = {d_rem, r_x[DIV_W-1-k]};
            if (d_t >= (REM_W+1)'(iohist_pkg::DIV_K)) begin
                d_rem           = REM_W'(d_t - (REM_W+1)'(iohist_pkg::DIV_K));
                d_bits[DIG-1-k] = 1'b1;
            end else begin
                d_rem = d_t[REM_W-1:0];
            end
        end
    end

    always_comb begin
        bin0_raw = r_q[FRAC_W +: BIN_W];
        bin0     = (NB_W'(bin0_raw) >= r_nb) ? BIN_W'(r_nb - NB_W'(1)) : bin0_raw;
        bin0_inc = NB_W'(bin0) + NB_W'(1);
        bin1     = (bin0_inc == r_nb) ? '0 : BIN_W'(bin0_inc);
        share_prod = {{MAG_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, r_q[FRAC_W-1:0]};
    end

    // Column wrap for narrow line stores, one subtract a cycle
    assign col_ge = (int'(r_col) >= MAX_WIDTH);
    assign push   = (r_state == S_PUSH) && !i_full && !col_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            if (r_state != S_IDLE && col_ge) begin
                r_col <= r_col - COL_W'(MAX_WIDTH);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mag   <= i_item.magnitude;
                        r_ang   <= i_item.angle;
                        r_col   <= i_item.column;
                        r_top   <= i_item.first_row;
                        r_clear <= (i_item.column == '0);
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    r_ang   <= ang_b;
                    r_nb    <= i_cfg.nb;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_x     <= x_val;
                    r_q     <= '0;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_x    <= r_x << DIG;
                    r_q    <= {r_q[DIV_W-DIG-1:0], d_bits};
                    r_rem  <= d_rem;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(iohist_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_bin0   <= bin0;
                    r_bin1   <= bin1;
                    r_share1 <= share_prod[2*MAG_W-1:MAG_W];
                    r_state  <= S_PUSH;
                end
                S_PUSH: begin
                    if (push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_push  = push;

    always_comb begin
        o_job.mag    = r_mag;
        o_job.share1 = r_share1;
        o_job.bin0   = r_bin0;
        o_job.bin1   = r_bin1;
        o_job.nb     = r_nb;
        o_job.col    = r_col;
        o_job.top    = r_top;
        o_job.clear  = r_clear;
    end

endmodule

@@ rtl/core/iohist_back.sv @@
// Back end: updates row sums, reads/writes the line store and queues results.
module iohist_back #(
    parameter int MAX_BINS  = iohist_pkg::MAX_BINS_DEF,
    parameter int MAX_WIDTH = iohist_pkg::MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    output logic                  o_pop,
    input  iohist_pkg::t_job      i_job,
    output logic                  o_valid,
    input  logic                  i_ready,
    output iohist_pkg::t_out_item o_item
);

    localparam int BIN_W  = iohist_pkg::BIN_W;
    localparam int NB_W   = iohist_pkg::NB_W;
    localparam int ROW_W  = iohist_pkg::ROW_W;
    localparam int INT_W  = iohist_pkg::INT_W;
    localparam int MAG_W  = iohist_pkg::MAG_W;
    localparam int DEPTH  = MAX_WIDTH * MAX_BINS;
    localparam int AW     = $clog2(DEPTH);
    localparam int BI_W   = $clog2(MAX_BINS);
    localparam int OQ     = iohist_pkg::OQ_DEPTH;
    localparam int OQ_W   = $clog2(OQ);
    localparam int OQC_W  = $clog2(OQ + 1);

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_state;

    t_state                 r_state;
    iohist_pkg::t_job       r_job;
    logic [BIN_W-1:0]       r_b;
    logic [ROW_W-1:0]       r_rows [MAX_BINS];

    logic                   r_s_valid;
    logic [AW-1:0]          r_s_addr;
    logic [ROW_W-1:0]       r_s_sum;
    logic [BIN_W-1:0]       r_s_bin;
    logic                   r_s_last;
    logic                   r_s_top;

    iohist_pkg::t_out_item  r_oq [OQ];
    logic [OQ_W-1:0]        r_wp;
    logic [OQ_W-1:0]        r_rp;
    logic [OQC_W-1:0]       r_cnt;

    logic                   pop;
    logic                   issue;
    logic                   last;
    logic [MAG_W-1:0]       add;
    logic [ROW_W:0]         sum_w;
    logic [ROW_W-1:0]       row_new;
    logic [AW-1:0]          raddr;
    logic [INT_W-1:0]       rdata;
    logic [INT_W:0]         v_w;
    logic [INT_W-1:0]       v;
    logic                   out_take;
    iohist_pkg::t_out_item  res;

    assign pop   = (r_state == B_IDLE) && !i_empty;
    // Keep room in the result queue for the read already in flight
    assign issue = (r_state == B_RUN)
                && ((OQC_W+1)'(r_cnt) + (OQC_W+1)'(r_s_valid) < (OQC_W+1)'(OQ));
    assign last  = ((NB_W'(r_b) + NB_W'(1)) == r_job.nb);

    // Each bin takes at most one of the two shares, as bin1 differs from bin0
    always_comb begin
        if (r_b == r_job.bin0) begin
            add = r_job.mag - r_job.share1;
        end else if (r_b == r_job.bin1) begin
            add = r_job.share1;
        end else begin
            add = '0;
        end
        sum_w   = {1'b0, r_rows[r_b[BI_W-1:0]]} + (ROW_W+1)'(add);
        row_new = sum_w[ROW_W] ? {ROW_W{1'b1}} : sum_w[ROW_W-1:0];
        raddr   = AW'(r_job.col) * AW'(MAX_BINS) + AW'(r_b);
    end

    iohist_ram #(
        .WIDTH (INT_W),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s_valid),
        .i_waddr (r_s_addr),
        .i_wdata (v),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        v_w = (r_s_top ? {(INT_W+1){1'b0}} : {1'b0, rdata}) + (INT_W+1)'(r_s_sum);
        v   = v_w[INT_W] ? {INT_W{1'b1}} : v_w[INT_W-1:0];
        res.bin_index      = iohist_pkg::OBIN_W'(r_s_bin);
        res.integral_value = v;
        res.last_bin       = r_s_last;
    end

    assign out_take = (r_cnt != '0) && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_s_valid <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
            for (int i = 0; i < MAX_BINS; i++) begin
                r_rows[i] <= '0;
            end
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (pop) begin
                        r_job   <= i_job;
                        r_b     <= '0;
                        r_state <= B_RUN;
                        if (i_job.clear) begin
                            for (int i = 0; i < MAX_BINS; i++) begin
                                r_rows[i] <= '0;
                            end
                        end
                    end
                end
                B_RUN: begin
                    if (issue) begin
                        r_rows[r_b[BI_W-1:0]] <= row_new;
                        r_b <= r_b + BIN_W'(1);
                        if (last) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase

            r_s_valid <= issue;
            if (issue) begin
                r_s_addr <= raddr;
                r_s_sum  <= row_new;
                r_s_bin  <= r_b;
                r_s_last <= last;
                r_s_top  <= r_job.top;
            end

            if (r_s_valid) begin
                r_oq[r_wp] <= res;
                r_wp <= (r_wp == OQ_W'(OQ - 1)) ? '0 : r_wp + OQ_W'(1);
            end
            if (out_take) begin
                r_rp <= (r_rp == OQ_W'(OQ - 1)) ? '0 : r_rp + OQ_W'(1);
            end
            r_cnt <= r_cnt + OQC_W'(r_s_valid) - OQC_W'(out_take);
        end
    end

    assign o_pop   = pop;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_oq[r_rp];

endmodule

@@ rtl/core/integral_orientation_histogram.sv @@
// The front end takes each pixel through reduction, multiply, an 8-step divider,
// magnitude split and push; the back end does one line-store read and write per bin.
// The job queue lets the front end classify the next pixel while the back end sweeps.
// Columns at or beyond MAX_WIDTH are wrapped in the front end by subtracting MAX_WIDTH.
// Reset (synchronous, active low): empty pipeline, row sums cleared,
// full_orientation = 0, num_bins = 8; the line store is not cleared.
module integral_orientation_histogram #(
    parameter int MAX_BINS  = iohist_pkg::MAX_BINS_DEF,
    parameter int MAX_WIDTH = iohist_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pixel items in
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  iohist_pkg::t_in_item                 i_in_item,
    // bin results out
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output iohist_pkg::t_out_item                o_out_item,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [iohist_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [iohist_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NB_W = iohist_pkg::NB_W;

    logic                                   r_full;
    logic [iohist_pkg::CFG_DATA_W-1:0]      r_num_bins;
    iohist_pkg::t_cfg                       w_cfg;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    iohist_pkg::t_job   q_in;
    iohist_pkg::t_job   q_out;

    // Configuration registers; the port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= 1'b0;
            r_num_bins <= iohist_pkg::NB_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                iohist_pkg::CFG_FULL_ORIENT: r_full     <= i_cfg_data[0];
                iohist_pkg::CFG_NUM_BINS:    r_num_bins <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Bin count in use, clamped to 2..MAX_BINS
    always_comb begin
        w_cfg.full = r_full;
        if (r_num_bins < iohist_pkg::NB_MIN) begin
            w_cfg.nb = NB_W'(iohist_pkg::NB_MIN);
        end else if (int'(r_num_bins) > MAX_BINS) begin
            w_cfg.nb = NB_W'(MAX_BINS);
        end else begin
            w_cfg.nb = NB_W'(r_num_bins);
        end
    end

    // Front end: angle reduction, bin position by division, magnitude split
    iohist_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_push  (q_push),
        .o_job   (q_in),
        .i_full  (q_full)
    );

    // Short queue so the front can classify the next item during a bin sweep
    iohist_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty)
    );

    // Back end: per-bin row sums, line store read-modify-write, result queue
    iohist_back #(
        .MAX_BINS  (MAX_BINS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_job   (q_out),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // The last result of a pixel carries the top bin in use
    a_last_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last_bin)
            |-> (o_out_item.bin_index == iohist_pkg::OBIN_W'(w_cfg.nb - NB_W'(1))))
        else $error("last_bin on a result that is not the top bin");

    // Front end holds one item at a time
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("front end took an item while busy");

    // No result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

@@ bench/integral_orientation_histogram_tb.sv @@
// Testbench for the integral orientation histogram: directed and random pixels, checked bin by bin.
module integral_orientation_histogram_tb;
    import iohist_pkg::*;

    // Bins and columns of the default build; the line store holds one entry per bin per column
    localparam int STORE_BINS  = MAX_BINS_DEF;
    localparam int STORE_DEPTH = MAX_BINS_DEF * MAX_WIDTH_DEF;
    localparam int COL_MAX     = (1 << COL_W) - 1;

    localparam longint unsigned ROW_SUM_MAX   = (64'd1 << ROW_W) - 1;
    localparam longint unsigned INTEGRAL_MAX  = (64'd1 << INT_W) - 1;

    // Pause once everything is back, before the next step
    localparam int LATENCY_PAUSE = 32;
    // Cycle limit for the whole run; the long saturation row dominates the run time
    localparam int CYCLE_LIMIT   = 2_000_000;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 37;
    localparam int SAT_ITEMS     = 19000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FULL_ORIENT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the configuration registers, as the block should hold them
    logic                  full_orient  = 1'b0;
    logic [CFG_DATA_W-1:0] num_bins_reg = NB_RESET;

    // Predictor state: running row sums and the previous-row integral line store
    longint unsigned row_sums [STORE_BINS]        = '{default: 0};
    longint unsigned integral_store [STORE_DEPTH] = '{default: 0};
    // Which line-store entries the stimulus has written so far
    bit              entry_written [STORE_DEPTH]  = '{default: 0};

    t_in_item  pixel_q[$];
    t_out_item bin_results_q[$];

    int unsigned pixels_queued   = 0;
    int unsigned pixels_accepted = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    int unsigned idle_pct        = 0;
    int unsigned in_gap          = 0;
    int unsigned out_stall       = 0;

    integral_orientation_histogram dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bin count register out of range is clamped: below 2 acts as 2, above 16 as 16
    function automatic int unsigned bins_in_use(input logic [CFG_DATA_W-1:0] val);
        if (val < NB_MIN) return NB_MIN;
        if (val > STORE_BINS) return STORE_BINS;
        return val;
    endfunction

    function automatic void add_to_row(input int unsigned bin, input longint unsigned amount);
        longint unsigned sum;
        sum = row_sums[bin] + amount;
        row_sums[bin] = (sum > ROW_SUM_MAX) ? ROW_SUM_MAX : sum;
    endfunction

    // Works out the bin results of one accepted pixel and queues them in bin order
    function automatic void predict_pixel(input t_in_item px);
        int unsigned     nb, bin0, bin1, addr;
        longint unsigned span, ang, pos, frac, share1, total;
        t_out_item       res;
        nb   = bins_in_use(num_bins_reg);
        span = full_orient ? RANGE_FULL : RANGE_HALF;
        // column zero opens a new row
        if (px.column == '0) foreach (row_sums[b]) row_sums[b] = 0;
        // fold into the orientation range, then place on the bin axis with a 16-bit fraction
        ang  = px.angle % span;
        pos  = (ang * nb * 64'd65536) / span;
        bin0 = pos >> FRAC_W;
        if (bin0 >= nb) bin0 = nb - 1;
        frac = pos & 64'hFFFF;
        bin1 = (bin0 + 1) % nb;
        // the split keeps the whole magnitude: bin0 takes the remainder
        share1 = (px.magnitude * frac) >> FRAC_W;
        add_to_row(bin0, px.magnitude - share1);
        add_to_row(bin1, share1);
        for (int unsigned b = 0; b < nb; b++) begin
            addr  = px.column * STORE_BINS + b;
            total = (px.first_row ? 64'd0 : integral_store[addr]) + row_sums[b];
            if (total > INTEGRAL_MAX) total = INTEGRAL_MAX;
            integral_store[addr] = total;
            res.bin_index      = b[OBIN_W-1:0];
            res.integral_value = total[INT_W-1:0];
            res.last_bin       = (b == nb - 1);
            bin_results_q.push_back(res);
        end
    endfunction

    function automatic logic [MAG_W-1:0] rand_mag();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom_range(16'hFFFF);
        endcase
    endfunction

    function automatic logic [ANG_W-1:0] rand_angle();
        return $urandom_range(RANGE_FULL - 1);
    endfunction

    // Queues one pixel. A pixel off the top row must only read line-store entries already
    // written for every bin in use; otherwise it is sent as a top-row pixel instead.
    task automatic queue_pixel(input logic [MAG_W-1:0] mag, input logic [ANG_W-1:0] ang,
                               input logic [COL_W-1:0] col, input logic top);
        t_in_item    px;
        int unsigned nb;
        nb = bins_in_use(num_bins_reg);
        for (int unsigned b = 0; b < nb; b++) begin
            if (!entry_written[col * STORE_BINS + b]) top = 1'b1;
            entry_written[col * STORE_BINS + b] = 1'b1;
        end
        px.magnitude = mag;
        px.angle     = ang;
        px.column    = col;
        px.first_row = top;
        pixel_q.push_back(px);
        pixels_queued++;
    endtask

    // A small frame in raster order: a first row mostly sent as top-row pixels, then rows reading the one above
    task automatic queue_frame(input int unsigned ncols, input int unsigned nrows);
        int unsigned cols[$];
        int unsigned step;
        cols.push_back(0);
        while (cols.size() < ncols) begin
            step = ($urandom_range(3) == 0) ? $urandom_range(400, 1) : $urandom_range(3, 1);
            if (cols[$] + step > COL_MAX) break;
            cols.push_back(cols[$] + step);
        end
        // now and then run the row out to the last column
        if ($urandom_range(3) == 0 && cols[$] != COL_MAX) cols.push_back(COL_MAX);
        for (int unsigned r = 0; r < nrows; r++)
            foreach (cols[i])
                queue_pixel(rand_mag(), rand_angle(), cols[i],
                            (r == 0) ? ($urandom_range(4) != 0) : 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FULL_ORIENT) full_orient = val[0];
        else if (idx == CFG_NUM_BINS) num_bins_reg = val;
    endtask

    // Holds the sender back until every queued pixel is in and every bin result is out
    task automatic wait_idle();
        while (pixels_accepted != pixels_queued || bin_results_q.size() != 0) @(posedge clk);
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    // Pixel driver: takes items from pixel_q, with random gaps between them
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_pixel(in_item);
                pixels_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    in_item  <= pixel_q.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(99) < idle_pct) in_gap = $urandom_range(5, 1);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each bin result with the oldest expectation
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (bin_results_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected bin result: bin %0d value %0d last %0b",
                                 out_item.bin_index, out_item.integral_value, out_item.last_bin);
                end else begin
                    want = bin_results_q.pop_front();
                    if (out_item.bin_index !== want.bin_index ||
                        out_item.integral_value !== want.integral_value ||
                        out_item.last_bin !== want.last_bin) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("bin result mismatch: expected bin %0d value %0d last %0b, %s",
                                     want.bin_index, want.integral_value, want.last_bin,
                                     $sformatf("got bin %0d value %0d last %0b",
                                               out_item.bin_index, out_item.integral_value,
                                               out_item.last_bin));
                    end
                end
            end
            // receiver stalls in short bursts
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(99) < idle_pct) out_stall = $urandom_range(5, 1);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic                  phase_full [RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        logic [CFG_DATA_W-1:0] phase_bins [RANDOM_PHASES] = '{5'd16, 5'd2, 5'd3, 5'd31, 5'd9, 5'd5};
        int unsigned           target;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct = 30;

        // Reset settings: half range, 8 bins
        queue_pixel(16'h0000, 16'd0, 10'd0, 1'b1);        // zero magnitude
        queue_pixel(16'hFFFF, 16'd0, 10'd1, 1'b1);        // all of it on bin 0
        queue_pixel(16'hFFFF, 16'd46079, 10'd2, 1'b1);    // largest angle, folded
        queue_pixel(16'h8000, 16'd23040, 10'd3, 1'b1);    // exactly 180 folds to 0
        queue_pixel(16'h7FFF, 16'd23039, 10'd4, 1'b1);    // top bin wraps into bin 0
        queue_pixel(16'h0001, 16'd1, 10'd5, 1'b1);        // smallest non-zero values
        queue_pixel(rand_mag(), 16'd2880, COL_MAX, 1'b1); // exact bin edge, last column
        queue_pixel(16'hFFFF, 16'd11520, 10'd0, 1'b0);    // second row reads the first
        queue_pixel(rand_mag(), rand_angle(), 10'd1, 1'b0);
        queue_pixel(rand_mag(), rand_angle(), COL_MAX, 1'b0);
        wait_idle();

        // Full range, bin count above the limit; spare data bits set on the 1-bit register
        write_reg(CFG_FULL_ORIENT, 5'b11111);
        write_reg(CFG_NUM_BINS, 5'd17);
        queue_pixel(16'hFFFF, 16'd46079, 10'd0, 1'b1);    // top bin wraps into bin 0
        queue_pixel(16'hFFFF, 16'd23040, 10'd1, 1'b1);    // 180 is not folded here
        queue_pixel(rand_mag(), rand_angle(), 10'd1, 1'b0);
        queue_pixel(16'h8001, 16'd12345, 10'd0, 1'b0);
        wait_idle();

        // Half range, bin count below the limit
        write_reg(CFG_FULL_ORIENT, 5'b11110);
        write_reg(CFG_NUM_BINS, 5'd0);
        queue_pixel(16'hFFFF, 16'd46079, 10'd0, 1'b1);
        queue_pixel(16'hFFFF, 16'd11519, 10'd1, 1'b0);
        queue_pixel(16'hFFFF, 16'd11520, 10'd2, 1'b1);
        wait_idle();
        write_reg(CFG_NUM_BINS, 5'd1);
        queue_pixel(rand_mag(), rand_angle(), 10'd0, 1'b0);
        queue_pixel(rand_mag(), rand_angle(), 10'd2, 1'b0);

        // Random phases: mostly small raster frames, some stray pixels anywhere
        phase_bins[RANDOM_PHASES - 1] = $urandom_range(15, 4);
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            write_reg(CFG_FULL_ORIENT, {4'($urandom), phase_full[p]});
            write_reg(CFG_NUM_BINS, phase_bins[p]);
            idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(50, 15);
            target = pixels_queued + PHASE_ITEMS;
            while (pixels_queued < target) begin
                if ($urandom_range(3) != 0)
                    queue_frame($urandom_range(8, 1), $urandom_range(4, 1));
                else
                    queue_pixel(rand_mag(), rand_angle(), 10'($urandom), $urandom_range(1));
            end
        end

        // Last part, no idling: one very long row at one column, so the row sums and then
        // the integral entries run into saturation; a final row start clears the sums
        wait_idle();
        write_reg(CFG_FULL_ORIENT, 5'd0);
        write_reg(CFG_NUM_BINS, 5'd2);
        idle_pct = 0;
        queue_pixel(16'hFFFF, rand_angle(), 10'd0, 1'b1);
        queue_pixel(16'hFFFF, rand_angle(), 10'd7, 1'b1);
        repeat (SAT_ITEMS) queue_pixel(16'hFFFF, rand_angle(), 10'd7, 1'b0);
        queue_pixel(16'hFFFF, rand_angle(), 10'd0, 1'b0);
        queue_pixel(16'hFFFF, rand_angle(), 10'd7, 1'b0);
        wait_idle();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/iohist_pkg.sv
rtl/core/iohist_ram.sv
rtl/core/iohist_queue.sv
rtl/core/iohist_front.sv
rtl/core/iohist_back.sv
rtl/core/integral_orientation_histogram.sv
bench/integral_orientation_histogram_tb.sv
